### hw/rtl/sls_pkg.sv
// Shared constants, types and control codes of the sorted table search block.
package sls_pkg;

  localparam int TableDepth = 1024;
  localparam int KeyWidth   = 32;
  localparam int IdxWidth   = $clog2(TableDepth);
  localparam int CountWidth = IdxWidth + 1;

  typedef enum logic [2:0] {
    StIdle,
    StLast,
    StOrder,
    StBisect,
    StDone
  } ctrl_state_e;

  typedef enum logic [1:0] {
    RdFirst,
    RdLast,
    RdMid
  } rd_sel_e;

  typedef struct packed {
    logic    wr_entry;
    logic    load_search;
    logic    capture_first;
    logic    set_order;
    logic    step;
    logic    issue_mid;
    logic    load_out;
    rd_sel_e rd_sel;
  } cmd_t;

  typedef struct packed {
    logic few_entries;
    logic gap_gt1;
    logic out_free;
  } status_t;

endpackage

### hw/rtl/sorted_table_left_neighbor_search.sv
// A write is taken in the idle state. A search over n >= 2 entries reads the first and last
// keys, then takes k <= ceil(log2(n-1)) bisection steps; below two entries it goes to done.
// One item at a time: the input stalls until the search result is loaded, with one dependent
// table read per bisection step, and longer while an earlier result still waits at the output.
// Reset clears the entry count, the controller and the result valid; table contents
// are undefined until written.
module sorted_table_left_neighbor_search import sls_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CountWidth-1:0]       cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        func_i,
  input  logic [IdxWidth-1:0]         entry_index_i,
  input  logic signed [KeyWidth-1:0]  entry_key_i,
  input  logic signed [KeyWidth-1:0]  target_key_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [IdxWidth-1:0]         left_index_o
);

  cmd_t    cmd;
  status_t status;

  sls_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .func_i    (func_i),
    .status_i  (status),
    .in_stall_o(in_stall_o),
    .cmd_o     (cmd)
  );

  sls_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .entry_index_i(entry_index_i),
    .entry_key_i  (entry_key_i),
    .target_key_i (target_key_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .left_index_o (left_index_o)
  );

`ifndef SYNTH
  // No input transfer while a search is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> !(cmd.capture_first || cmd.set_order || cmd.step))
    else $error("input transfer during a search");

  // A waiting result is never overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> status.out_free)
    else $error("result register overwritten");

  // The end keys are read in order: first key capture is followed by the order decision.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture_first |=> cmd.set_order)
    else $error("order check did not follow first key capture");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load_search, cmd.capture_first, cmd.set_order, cmd.step, cmd.load_out}))
    else $error("conflicting datapath commands");
`endif

endmodule

### hw/rtl/sls_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module sls_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/sls_dp.sv
// Datapath: key table, count register, bisection bounds and result register.
module sls_dp import sls_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CountWidth-1:0]        cfg_wdata_i,
  input  logic [IdxWidth-1:0]          entry_index_i,
  input  logic signed [KeyWidth-1:0]   entry_key_i,
  input  logic signed [KeyWidth-1:0]   target_key_i,
  input  cmd_t                         cmd_i,
  output status_t                      status_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [IdxWidth-1:0]          left_index_o
);

  logic [CountWidth-1:0]       count_q;
  logic [CountWidth-1:0]       count_eff;
  logic [IdxWidth-1:0]         left_q, right_q, mid_q;
  logic [IdxWidth-1:0]         left_d, right_d, mid_d;
  logic signed [KeyWidth-1:0]  target_q;
  logic signed [KeyWidth-1:0]  first_q;
  logic                        asc_q;
  logic                        out_valid_q;
  logic [IdxWidth-1:0]         out_idx_q;
  logic [IdxWidth-1:0]         raddr;
  logic [KeyWidth-1:0]         rdata;
  logic                        at_or_above;
  logic                        wr_ok;

  sls_ram #(
    .Width(KeyWidth),
    .Depth(TableDepth)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_entry && wr_ok),
    .waddr_i(entry_index_i),
    .wdata_i(entry_key_i),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign wr_ok = 32'(entry_index_i) < TableDepth;

  // Counts above the table depth search the whole table.
  assign count_eff = (count_q > CountWidth'(TableDepth)) ? CountWidth'(TableDepth) : count_q;

  // The bounds update from the key read for the previous midpoint, and the
  // next midpoint is addressed in the same cycle.
  assign at_or_above = target_q >= $signed(rdata);

  always_comb begin
    left_d  = left_q;
    right_d = right_q;
    if (cmd_i.step) begin
      if (at_or_above == asc_q) begin
        left_d = mid_q;
      end else begin
        right_d = mid_q;
      end
    end
    mid_d = IdxWidth'((CountWidth'(left_d) + CountWidth'(right_d)) >> 1);
  end

  always_comb begin
    case (cmd_i.rd_sel)
      RdFirst: raddr = '0;
      RdLast:  raddr = right_q;
      RdMid:   raddr = mid_d;
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_search) begin
      left_q   <= '0;
      right_q  <= IdxWidth'(count_eff - CountWidth'(1));
      target_q <= target_key_i;
    end else begin
      left_q  <= left_d;
      right_q <= right_d;
    end
    if (cmd_i.issue_mid) begin
      mid_q <= mid_d;
    end
    if (cmd_i.capture_first) begin
      first_q <= $signed(rdata);
    end
    if (cmd_i.set_order) begin
      asc_q <= $signed(rdata) >= first_q;
    end
    if (cmd_i.load_out) begin
      out_idx_q <= left_q;
    end
  end

  assign status_o.few_entries = count_eff < CountWidth'(2);
  assign status_o.gap_gt1     = (right_d - left_d) > IdxWidth'(1);
  assign status_o.out_free    = !out_valid_q || !out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign left_index_o = out_idx_q;

endmodule

### hw/rtl/sls_ctrl.sv
// Controller state machine that sequences table writes and bisection searches.
module sls_ctrl import sls_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    func_i,
  input  status_t status_i,
  output logic    in_stall_o,
  output cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != StIdle;
  assign accept     = in_valid_i && (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_sel = RdFirst;
    case (state_q)
      StIdle: begin
        // The first key is read on every idle cycle, so it is ready when a
        // search is accepted.
        if (accept) begin
          if (!func_i) begin
            cmd_o.wr_entry = 1'b1;
          end else begin
            cmd_o.load_search = 1'b1;
            state_d = status_i.few_entries ? StDone : StLast;
          end
        end
      end
      StLast: begin
        cmd_o.capture_first = 1'b1;
        cmd_o.rd_sel        = RdLast;
        state_d             = StOrder;
      end
      StOrder: begin
        cmd_o.set_order = 1'b1;
        if (status_i.gap_gt1) begin
          cmd_o.rd_sel    = RdMid;
          cmd_o.issue_mid = 1'b1;
          state_d         = StBisect;
        end else begin
          state_d = StDone;
        end
      end
      StBisect: begin
        cmd_o.step = 1'b1;
        if (status_i.gap_gt1) begin
          cmd_o.rd_sel    = RdMid;
          cmd_o.issue_mid = 1'b1;
        end else begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule
